[src/vnn_pkg.sv]
package vnn_pkg;

    localparam int DATA_W    = 24;
    localparam int VALUE_W   = 32;
    localparam int ACC_W     = 64;
    localparam int MODE_W    = 3;
    localparam int MAX_LEN   = 64;
    localparam int FRAC_BITS = 16;

    localparam int ADDR_W   = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
    localparam int CNT_W    = $clog2(MAX_LEN + 1);
    localparam int MAG_W    = DATA_W;
    localparam int PROD_W   = 2 * MAG_W;
    localparam int ROOT_W   = ACC_W / 2;
    localparam int DIV_W    = DATA_W + FRAC_BITS;
    localparam int STEP_MAX = (DIV_W > ROOT_W) ? DIV_W : ROOT_W;
    localparam int STEP_W   = $clog2(STEP_MAX);

    typedef enum logic [MODE_W-1:0] {
        MODE_L2     = 3'd0,
        MODE_L1     = 3'd1,
        MODE_MAXMAG = 3'd2,
        MODE_MIN    = 3'd3,
        MODE_MAX    = 3'd4,
        MODE_DIST   = 3'd5,
        MODE_L2N    = 3'd6,
        MODE_L1N    = 3'd7
    } t_mode;

endpackage

[src/vnn_if.sv]
interface vnn_in_if;
    logic                       valid;
    logic                       ready;
    logic [vnn_pkg::DATA_W-1:0] elem_a;
    logic [vnn_pkg::DATA_W-1:0] elem_b;
    logic                       is_last;

    modport source (output valid, output elem_a, output elem_b, output is_last, input ready);
    modport sink (input valid, input elem_a, input elem_b, input is_last, output ready);
endinterface

interface vnn_out_if;
    logic                        valid;
    logic                        ready;
    logic [vnn_pkg::VALUE_W-1:0] value;
    logic                        zero_norm;
    logic                        overflow;
    logic                        last_out;

    modport source (output valid, output value, output zero_norm, output overflow,
                    output last_out, input ready);
    modport sink (input valid, input value, input zero_norm, input overflow,
                  input last_out, output ready);
endinterface

interface vnn_cfg_if;
    logic                       valid;
    logic                       ready;
    logic [vnn_pkg::MODE_W-1:0] data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

[src/vector_norm_normalize_engine.sv]
// Vector norm and normalize engine.
// Elements of a vector arrive as beats on i_in (signed Q7.16, is_last on the final
// beat); results leave as beats on o_out. The mode register is written through i_cfg,
// which is ready only while the engine is idle; a write abandons the vector in progress.
// Per element: L1 and the extreme modes update on the accepted beat, the squaring modes
// (L2, distance, L2 normalize) run the bit-serial shift-add multiplier (24 steps), then accumulate.
// After the last element: the square-root modes run a bit-serial root of 32 steps; L2
// and distance then load one result beat, as do L1 and the extreme modes. The normalize
// modes read each stored element from the 64-entry element memory and divide it by the norm
// with a bit-serial restoring divider of 40 steps, skipped when the norm is zero.
// Results go through a single output register. A new vector is accepted while the final
// result of the previous one waits there. When the receiver stalls, the engine holds in
// its current result state until the output register is free. Synchronous active-low
// reset returns the engine to idle with mode 0 and an empty vector; the element memory is
// not cleared, since only entries written for the current vector are ever read.
module vector_norm_normalize_engine (
    input  logic     i_clk,
    input  logic     i_rst_n,
    vnn_in_if.sink   i_in,
    vnn_out_if.source o_out,
    vnn_cfg_if.sink  i_cfg
);

    localparam int DATA_W  = vnn_pkg::DATA_W;
    localparam int VALUE_W = vnn_pkg::VALUE_W;
    localparam int ACC_W   = vnn_pkg::ACC_W;
    localparam int ADDR_W  = vnn_pkg::ADDR_W;
    localparam int CNT_W   = vnn_pkg::CNT_W;
    localparam int MAG_W   = vnn_pkg::MAG_W;
    localparam int PROD_W  = vnn_pkg::PROD_W;
    localparam int ROOT_W  = vnn_pkg::ROOT_W;
    localparam int DIV_W   = vnn_pkg::DIV_W;
    localparam int STEP_W  = vnn_pkg::STEP_W;
    localparam int FRAC    = vnn_pkg::FRAC_BITS;
    localparam int MAX_LEN = vnn_pkg::MAX_LEN;

    typedef enum logic [9:0] {
        S_IDLE     = 10'b0000000001,
        S_MUL      = 10'b0000000010,
        S_ACC      = 10'b0000000100,
        S_FIN      = 10'b0000001000,
        S_SQRT     = 10'b0000010000,
        S_RED_OUT  = 10'b0000100000,
        S_NORM_RD  = 10'b0001000000,
        S_DSET     = 10'b0010000000,
        S_DIV      = 10'b0100000000,
        S_NORM_OUT = 10'b1000000000
    } t_state;

    function automatic logic [VALUE_W-1:0] sat_pos(input logic [ACC_W-1:0] m);
        logic big;
        big = |m[ACC_W-1:VALUE_W-1];
        return big ? {1'b0, {(VALUE_W-1){1'b1}}} : m[VALUE_W-1:0];
    endfunction

    function automatic logic [VALUE_W-1:0] sat_signed(input logic neg,
                                                     input logic [ACC_W-1:0] m);
        logic big;
        big = |m[ACC_W-1:VALUE_W-1];
        if (neg) begin
            return big ? {1'b1, {(VALUE_W-1){1'b0}}} : (~m[VALUE_W-1:0] + VALUE_W'(1));
        end
        return sat_pos(m);
    endfunction

    function automatic logic [MAG_W-1:0] mag24(input logic [DATA_W-1:0] v);
        return v[DATA_W-1] ? (~v + DATA_W'(1)) : v;
    endfunction

    t_state              r_state;
    vnn_pkg::t_mode      r_mode;
    logic [ACC_W-1:0]    r_acc;
    logic [DATA_W-1:0]   r_ext;
    logic [CNT_W-1:0]    r_count;
    logic                r_first;
    logic                r_ovf;
    logic                r_last;
    logic [STEP_W-1:0]   r_cnt;
    logic [MAG_W-1:0]    r_mcand;
    logic [PROD_W-1:0]   r_prod;
    logic [ACC_W-1:0]    r_rad;
    logic [ROOT_W+1:0]   r_sq_rem;
    logic [ROOT_W-1:0]   r_root;
    logic [ACC_W-1:0]    r_norm;
    logic [CNT_W-1:0]    r_k;
    logic [DATA_W-1:0]   r_rd;
    logic [DATA_W-1:0]   r_elem;
    logic                r_neg;
    logic [DIV_W-1:0]    r_dq;
    logic [DIV_W-1:0]    r_dv_rem;
    logic                r_out_valid;
    logic [VALUE_W-1:0]  r_out_value;
    logic                r_out_zero;
    logic                r_out_ovf;
    logic                r_out_last;
    logic [DATA_W-1:0]   r_mem [MAX_LEN];

    logic                w_in_fire;
    logic                w_cfg_fire;
    logic                w_out_free;
    logic                w_out_load;
    logic                w_room;
    logic                w_go_mul;
    logic [MAG_W-1:0]    w_mag_a;
    logic [DATA_W:0]     w_diff;
    logic [MAG_W-1:0]    w_mag_d;
    logic [ACC_W-1:0]    w_acc_in;
    logic [ACC_W:0]      w_acc_sum;
    logic [MAG_W:0]      w_mul_sum;
    logic [ROOT_W+3:0]   w_sq_sh;
    logic [ROOT_W+3:0]   w_sq_trial;
    logic                w_sq_ge;
    logic [ROOT_W-1:0]   w_root_nx;
    logic [DIV_W:0]      w_dv_sh;
    logic                w_dv_ge;
    logic                w_norm_last;
    logic [VALUE_W-1:0]  w_red_value;
    logic [VALUE_W-1:0]  w_norm_value;

    assign w_in_fire  = i_in.valid && i_in.ready;
    assign w_cfg_fire = i_cfg.valid && i_cfg.ready;
    assign w_out_free = !r_out_valid || o_out.ready;
    assign w_out_load = ((r_state == S_RED_OUT) || (r_state == S_NORM_OUT)) && w_out_free;
    assign w_room     = r_count < CNT_W'(MAX_LEN);
    assign w_go_mul   = w_room && ((r_mode == vnn_pkg::MODE_L2) ||
                                   (r_mode == vnn_pkg::MODE_L2N) ||
                                   (r_mode == vnn_pkg::MODE_DIST));

    assign i_cfg.ready = (r_state == S_IDLE);
    assign i_in.ready  = (r_state == S_IDLE) && !i_cfg.valid;

    assign o_out.valid     = r_out_valid;
    assign o_out.value     = r_out_value;
    assign o_out.zero_norm = r_out_zero;
    assign o_out.overflow  = r_out_ovf;
    assign o_out.last_out  = r_out_last;

    assign w_mag_a = mag24(i_in.elem_a);
    assign w_diff  = {i_in.elem_a[DATA_W-1], i_in.elem_a} - {i_in.elem_b[DATA_W-1], i_in.elem_b};
    assign w_mag_d = w_diff[DATA_W] ? MAG_W'(~w_diff + (DATA_W+1)'(1)) : w_diff[MAG_W-1:0];

    assign w_acc_in  = (r_state == S_ACC) ? ACC_W'(r_prod) : ACC_W'(w_mag_a);
    assign w_acc_sum = {1'b0, r_acc} + {1'b0, w_acc_in};

    assign w_mul_sum = {1'b0, r_prod[PROD_W-1:MAG_W]} + (r_prod[0] ? {1'b0, r_mcand} : '0);

    assign w_sq_sh    = {r_sq_rem, r_rad[ACC_W-1 -: 2]};
    assign w_sq_trial = {2'b00, r_root, 2'b01};
    assign w_sq_ge    = w_sq_sh >= w_sq_trial;
    assign w_root_nx  = {r_root[ROOT_W-2:0], w_sq_ge};

    assign w_dv_sh = {r_dv_rem, r_dq[DIV_W-1]};
    assign w_dv_ge = ACC_W'(w_dv_sh) >= r_norm;

    assign w_norm_last = (r_k + CNT_W'(1)) == r_count;

    always_comb begin
        unique case (r_mode)
            vnn_pkg::MODE_L2, vnn_pkg::MODE_DIST, vnn_pkg::MODE_L2N: begin
                w_red_value = sat_pos(ACC_W'(r_root));
            end
            vnn_pkg::MODE_L1, vnn_pkg::MODE_L1N: begin
                w_red_value = sat_pos(r_acc);
            end
            vnn_pkg::MODE_MAXMAG: begin
                w_red_value = VALUE_W'(r_ext);
            end
            vnn_pkg::MODE_MIN, vnn_pkg::MODE_MAX: begin
                w_red_value = VALUE_W'($signed(r_ext));
            end
        endcase
    end

    assign w_norm_value = (r_norm == '0) ? VALUE_W'($signed(r_elem))
                                         : sat_signed(r_neg, ACC_W'(r_dq));

    always_ff @(posedge i_clk) begin
        if (w_in_fire && w_room) begin
            r_mem[r_count[ADDR_W-1:0]] <= i_in.elem_a;
        end
        r_rd <= r_mem[r_k[ADDR_W-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_mode      <= vnn_pkg::MODE_L2;
            r_acc       <= '0;
            r_ext       <= '0;
            r_count     <= '0;
            r_first     <= 1'b0;
            r_ovf       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_out_load) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (w_cfg_fire) begin
                        r_mode  <= vnn_pkg::t_mode'(i_cfg.data);
                        r_acc   <= '0;
                        r_ext   <= '0;
                        r_count <= '0;
                        r_first <= 1'b0;
                        r_ovf   <= 1'b0;
                    end else if (w_in_fire) begin
                        r_last  <= i_in.is_last;
                        r_state <= w_go_mul ? S_MUL : (i_in.is_last ? S_FIN : S_IDLE);
                        if (!w_room) begin
                            r_ovf <= 1'b1;
                        end else begin
                            r_count <= r_count + CNT_W'(1);
                            r_first <= 1'b1;
                            unique case (r_mode)
                                vnn_pkg::MODE_L2, vnn_pkg::MODE_L2N: begin
                                    r_mcand <= w_mag_a;
                                    r_prod  <= PROD_W'(w_mag_a);
                                    r_cnt   <= STEP_W'(MAG_W - 1);
                                end
                                vnn_pkg::MODE_DIST: begin
                                    r_mcand <= w_mag_d;
                                    r_prod  <= PROD_W'(w_mag_d);
                                    r_cnt   <= STEP_W'(MAG_W - 1);
                                end
                                vnn_pkg::MODE_L1, vnn_pkg::MODE_L1N: begin
                                    if (w_acc_sum[ACC_W]) begin
                                        r_acc <= '1;
                                        r_ovf <= 1'b1;
                                    end else begin
                                        r_acc <= w_acc_sum[ACC_W-1:0];
                                    end
                                end
                                vnn_pkg::MODE_MAXMAG: begin
                                    if (!r_first || w_mag_a > r_ext) begin
                                        r_ext <= w_mag_a;
                                    end
                                end
                                vnn_pkg::MODE_MIN: begin
                                    if (!r_first || $signed(i_in.elem_a) < $signed(r_ext)) begin
                                        r_ext <= i_in.elem_a;
                                    end
                                end
                                vnn_pkg::MODE_MAX: begin
                                    if (!r_first || $signed(i_in.elem_a) > $signed(r_ext)) begin
                                        r_ext <= i_in.elem_a;
                                    end
                                end
                            endcase
                        end
                    end
                end
                S_MUL: begin
                    r_prod <= {w_mul_sum, r_prod[MAG_W-1:1]};
                    if (r_cnt == '0) begin
                        r_state <= S_ACC;
                    end else begin
                        r_cnt <= r_cnt - STEP_W'(1);
                    end
                end
                S_ACC: begin
                    if (w_acc_sum[ACC_W]) begin
                        r_acc <= '1;
                        r_ovf <= 1'b1;
                    end else begin
                        r_acc <= w_acc_sum[ACC_W-1:0];
                    end
                    r_state <= r_last ? S_FIN : S_IDLE;
                end
                S_FIN: begin
                    unique case (r_mode)
                        vnn_pkg::MODE_L2, vnn_pkg::MODE_DIST, vnn_pkg::MODE_L2N: begin
                            r_rad    <= r_acc;
                            r_sq_rem <= '0;
                            r_root   <= '0;
                            r_cnt    <= STEP_W'(ROOT_W - 1);
                            r_state  <= S_SQRT;
                        end
                        vnn_pkg::MODE_L1N: begin
                            r_norm  <= r_acc;
                            r_k     <= '0;
                            r_state <= S_NORM_RD;
                        end
                        vnn_pkg::MODE_L1, vnn_pkg::MODE_MAXMAG, vnn_pkg::MODE_MIN,
                        vnn_pkg::MODE_MAX: begin
                            r_state <= S_RED_OUT;
                        end
                    endcase
                end
                S_SQRT: begin
                    r_rad  <= {r_rad[ACC_W-3:0], 2'b00};
                    r_root <= w_root_nx;
                    if (w_sq_ge) begin
                        r_sq_rem <= (ROOT_W+2)'(w_sq_sh - w_sq_trial);
                    end else begin
                        r_sq_rem <= w_sq_sh[ROOT_W+1:0];
                    end
                    if (r_cnt == '0) begin
                        if (r_mode == vnn_pkg::MODE_L2N) begin
                            r_norm  <= ACC_W'(w_root_nx);
                            r_k     <= '0;
                            r_state <= S_NORM_RD;
                        end else begin
                            r_state <= S_RED_OUT;
                        end
                    end else begin
                        r_cnt <= r_cnt - STEP_W'(1);
                    end
                end
                S_RED_OUT: begin
                    if (w_out_free) begin
                        r_out_value <= w_red_value;
                        r_out_zero  <= 1'b0;
                        r_out_ovf   <= r_ovf;
                        r_out_last  <= 1'b1;
                        r_acc       <= '0;
                        r_ext       <= '0;
                        r_count     <= '0;
                        r_first     <= 1'b0;
                        r_ovf       <= 1'b0;
                        r_state     <= S_IDLE;
                    end
                end
                S_NORM_RD: begin
                    r_state <= S_DSET;
                end
                S_DSET: begin
                    r_elem   <= r_rd;
                    r_neg    <= r_rd[DATA_W-1];
                    r_dq     <= {mag24(r_rd), {FRAC{1'b0}}};
                    r_dv_rem <= '0;
                    r_cnt    <= STEP_W'(DIV_W - 1);
                    r_state  <= (r_norm == '0) ? S_NORM_OUT : S_DIV;
                end
                S_DIV: begin
                    r_dq <= {r_dq[DIV_W-2:0], w_dv_ge};
                    if (w_dv_ge) begin
                        r_dv_rem <= DIV_W'(w_dv_sh - r_norm[DIV_W:0]);
                    end else begin
                        r_dv_rem <= w_dv_sh[DIV_W-1:0];
                    end
                    if (r_cnt == '0) begin
                        r_state <= S_NORM_OUT;
                    end else begin
                        r_cnt <= r_cnt - STEP_W'(1);
                    end
                end
                S_NORM_OUT: begin
                    if (w_out_free) begin
                        r_out_value <= w_norm_value;
                        r_out_zero  <= (r_norm == '0);
                        r_out_ovf   <= r_ovf;
                        r_out_last  <= w_norm_last;
                        if (w_norm_last) begin
                            r_acc   <= '0;
                            r_ext   <= '0;
                            r_count <= '0;
                            r_first <= 1'b0;
                            r_ovf   <= 1'b0;
                            r_state <= S_IDLE;
                        end else begin
                            r_k     <= r_k + CNT_W'(1);
                            r_state <= S_NORM_RD;
                        end
                    end
                end
            endcase
        end
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(MAX_LEN))
        else $error("Element count exceeds the store depth.");

    a_div_norm: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_DIV |-> r_norm != '0)
        else $error("Division started with a zero norm.");

    a_read_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_NORM_RD |-> r_k < r_count)
        else $error("Normalize read beyond the stored elements.");

    a_last_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_NORM_OUT && w_out_free && w_norm_last) |=>
            (r_count == '0 && r_state == S_IDLE && r_out_last))
        else $error("Final normalize beat did not end the vector.");

endmodule

[tb/sv/testbench.sv]
`timescale 1ns / 1ps

module testbench;

    localparam int STALL_LIMIT  = 4000;
    localparam int HOLD_CYCLES  = 400;
    localparam int SETTLE       = 64;
    localparam int IDLE_PERCENT = 26;
    localparam int RANDOM_ITEMS = 20;

    typedef struct packed {
        logic [vnn_pkg::VALUE_W-1:0] value;
        logic                        zero_norm;
        logic                        overflow;
        logic                        last_out;
    } t_norm_result;

    logic clk = 1'b0;
    logic rst_n;

    vnn_in_if  in_if();
    vnn_out_if out_if();
    vnn_cfg_if cfg_if();

    vector_norm_normalize_engine u_top (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_in    (in_if),
        .o_out   (out_if),
        .i_cfg   (cfg_if)
    );

    always #2 clk = ~clk;

    vnn_pkg::t_mode              cur_mode;
    logic [vnn_pkg::DATA_W-1:0]  elem_mem [vnn_pkg::MAX_LEN];
    logic [vnn_pkg::ACC_W-1:0]   sum_acc;
    logic [vnn_pkg::DATA_W-1:0]  extreme;
    int unsigned                 n_elems;
    bit                          seen_any;
    bit                          dropped_or_sat;

    t_norm_result queued_values[$];
    int           failures   = 0;
    int           items_sent = 0;
    bit           idle_on    = 1'b1;
    bit           hold_req   = 1'b0;
    int           hold_left  = 0;

    function automatic logic [vnn_pkg::ACC_W-1:0] mag24(logic [vnn_pkg::DATA_W-1:0] v);
        return v[vnn_pkg::DATA_W-1]
            ? (64'd0 - {{(vnn_pkg::ACC_W-vnn_pkg::DATA_W){1'b1}}, v})
            : {{(vnn_pkg::ACC_W-vnn_pkg::DATA_W){1'b0}}, v};
    endfunction

    function automatic logic [vnn_pkg::ACC_W-1:0] int_sqrt(logic [vnn_pkg::ACC_W-1:0] n);
        logic [vnn_pkg::ACC_W-1:0] root;
        logic [vnn_pkg::ACC_W-1:0] bitv;
        root = '0;
        bitv = 64'd1 << 62;
        while (bitv > n) bitv = bitv >> 2;
        while (bitv != 0) begin
            if (n >= root + bitv) begin
                n    = n - (root + bitv);
                root = (root >> 1) + bitv;
            end else begin
                root = root >> 1;
            end
            bitv = bitv >> 2;
        end
        return root;
    endfunction

    function automatic logic [vnn_pkg::VALUE_W-1:0] sat_pos(logic [vnn_pkg::ACC_W-1:0] m);
        return (m > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : m[vnn_pkg::VALUE_W-1:0];
    endfunction

    function automatic logic [vnn_pkg::VALUE_W-1:0] sat_signed(bit neg,
                                                               logic [vnn_pkg::ACC_W-1:0] m);
        if (!neg) return sat_pos(m);
        if (m >= 64'h8000_0000) return 32'h8000_0000;
        return 32'd0 - m[vnn_pkg::VALUE_W-1:0];
    endfunction

    function automatic void clear_vector();
        sum_acc        = '0;
        extreme        = '0;
        n_elems        = 0;
        seen_any       = 1'b0;
        dropped_or_sat = 1'b0;
    endfunction

    function automatic void add_sum(logic [vnn_pkg::ACC_W-1:0] x);
        logic [vnn_pkg::ACC_W-1:0] s;
        s = sum_acc + x;
        if (s < sum_acc) begin
            s              = '1;
            dropped_or_sat = 1'b1;
        end
        sum_acc = s;
    endfunction

    function automatic void accumulate_element(logic [vnn_pkg::DATA_W-1:0] a,
                                               logic [vnn_pkg::DATA_W-1:0] b,
                                               logic last);
        logic [vnn_pkg::ACC_W-1:0]      ma;
        logic [vnn_pkg::ACC_W-1:0]      d;
        logic [vnn_pkg::ACC_W-1:0]      norm;
        logic [vnn_pkg::ACC_W-1:0]      q;
        logic signed [vnn_pkg::DATA_W:0] diff;
        logic [vnn_pkg::DATA_W-1:0]     e;
        t_norm_result                   r;
        if (n_elems >= vnn_pkg::MAX_LEN) begin
            dropped_or_sat = 1'b1;
        end else begin
            ma = mag24(a);
            elem_mem[n_elems] = a;
            n_elems++;
            case (cur_mode)
                vnn_pkg::MODE_L2, vnn_pkg::MODE_L2N: add_sum(ma * ma);
                vnn_pkg::MODE_L1, vnn_pkg::MODE_L1N: add_sum(ma);
                vnn_pkg::MODE_MAXMAG:
                    if (!seen_any || ma > {40'd0, extreme}) extreme = ma[vnn_pkg::DATA_W-1:0];
                vnn_pkg::MODE_MIN: if (!seen_any || $signed(a) < $signed(extreme)) extreme = a;
                vnn_pkg::MODE_MAX: if (!seen_any || $signed(a) > $signed(extreme)) extreme = a;
                default: begin
                    diff = $signed({a[vnn_pkg::DATA_W-1], a}) - $signed({b[vnn_pkg::DATA_W-1], b});
                    d    = diff[vnn_pkg::DATA_W] ? 64'(-diff) : 64'(diff);
                    add_sum(d * d);
                end
            endcase
            seen_any = 1'b1;
        end
        if (!last) return;
        if (cur_mode == vnn_pkg::MODE_L2N || cur_mode == vnn_pkg::MODE_L1N) begin
            norm = (cur_mode == vnn_pkg::MODE_L2N) ? int_sqrt(sum_acc) : sum_acc;
            for (int k = 0; k < n_elems; k++) begin
                e = elem_mem[k];
                if (norm == 0) begin
                    r.value = {{(vnn_pkg::VALUE_W-vnn_pkg::DATA_W){e[vnn_pkg::DATA_W-1]}}, e};
                end else begin
                    q       = (mag24(e) << vnn_pkg::FRAC_BITS) / norm;
                    r.value = sat_signed(e[vnn_pkg::DATA_W-1], q);
                end
                r.zero_norm = (norm == 0);
                r.overflow  = dropped_or_sat;
                r.last_out  = (k + 1 == n_elems);
                queued_values.push_back(r);
            end
        end else begin
            case (cur_mode)
                vnn_pkg::MODE_L2, vnn_pkg::MODE_DIST: r.value = sat_pos(int_sqrt(sum_acc));
                vnn_pkg::MODE_L1: r.value = sat_pos(sum_acc);
                vnn_pkg::MODE_MAXMAG:
                    r.value = {{(vnn_pkg::VALUE_W-vnn_pkg::DATA_W){1'b0}}, extreme};
                default:
                    r.value = {{(vnn_pkg::VALUE_W-vnn_pkg::DATA_W){extreme[vnn_pkg::DATA_W-1]}},
                               extreme};
            endcase
            r.zero_norm = 1'b0;
            r.overflow  = dropped_or_sat;
            r.last_out  = 1'b1;
            queued_values.push_back(r);
        end
        clear_vector();
    endfunction

    function automatic void check_field(string name, logic [vnn_pkg::VALUE_W-1:0] want,
                                        logic [vnn_pkg::VALUE_W-1:0] got);
        if (got !== want) begin
            failures++;
            $display("%0t: %s mismatch: expected %h, actual %h", $time, name, want, got);
        end
    endfunction

    task automatic check_result();
        t_norm_result want;
        if (queued_values.size() == 0) begin
            failures++;
            $display("%0t: result beat with nothing expected: expected none, actual %h",
                     $time, out_if.value);
        end else begin
            want = queued_values.pop_front();
            check_field("value", want.value, out_if.value);
            check_field("zero_norm", vnn_pkg::VALUE_W'(want.zero_norm),
                        vnn_pkg::VALUE_W'(out_if.zero_norm));
            check_field("overflow", vnn_pkg::VALUE_W'(want.overflow),
                        vnn_pkg::VALUE_W'(out_if.overflow));
            check_field("last_out", vnn_pkg::VALUE_W'(want.last_out),
                        vnn_pkg::VALUE_W'(out_if.last_out));
        end
    endtask

    always @(posedge clk) begin
        if (rst_n === 1'b1 && out_if.valid === 1'b1 && out_if.ready === 1'b1) begin
            check_result();
        end
    end

    initial begin
        out_if.ready = 1'b0;
        forever begin
            @(negedge clk);
            if (hold_req) begin
                hold_req  = 1'b0;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                out_if.ready <= 1'b0;
            end else begin
                out_if.ready <= !(idle_on && $urandom_range(99) < IDLE_PERCENT);
            end
        end
    end

    initial begin
        int stall_cycles;
        stall_cycles = 0;
        while (stall_cycles < STALL_LIMIT) begin
            @(posedge clk);
            if ((in_if.valid === 1'b1 && in_if.ready === 1'b1) ||
                (out_if.valid === 1'b1 && out_if.ready === 1'b1) ||
                (cfg_if.valid === 1'b1 && cfg_if.ready === 1'b1)) begin
                stall_cycles = 0;
            end else begin
                stall_cycles++;
            end
        end
        $display("Simulation FAILED");
        $finish;
    end

    task automatic send_element(input logic [vnn_pkg::DATA_W-1:0] a,
                                input logic [vnn_pkg::DATA_W-1:0] b,
                                input logic last);
        @(negedge clk);
        while (idle_on && $urandom_range(99) < IDLE_PERCENT) begin
            in_if.valid <= 1'b0;
            @(negedge clk);
        end
        in_if.valid   <= 1'b1;
        in_if.elem_a  <= a;
        in_if.elem_b  <= b;
        in_if.is_last <= last;
        do @(posedge clk); while (in_if.ready !== 1'b1);
        accumulate_element(a, b, last);
        items_sent++;
    endtask

    task automatic wait_quiet();
        @(negedge clk);
        in_if.valid <= 1'b0;
        while (queued_values.size() != 0) @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic set_mode(input vnn_pkg::t_mode m);
        wait_quiet();
        @(negedge clk);
        cfg_if.valid <= 1'b1;
        cfg_if.data  <= m;
        do @(posedge clk); while (cfg_if.ready !== 1'b1);
        cur_mode = m;
        clear_vector();
        @(negedge clk);
        cfg_if.valid <= 1'b0;
    endtask

    function automatic logic [vnn_pkg::DATA_W-1:0] rand_elem();
        case ($urandom_range(3))
            0: return vnn_pkg::DATA_W'(int'($urandom_range(1023)) - 512);
            1: return $urandom_range(1) ? 24'h7F_FFFF : 24'h80_0000;
            default: return vnn_pkg::DATA_W'($urandom);
        endcase
    endfunction

    task automatic send_vector(input int len);
        for (int k = 0; k < len; k++) begin
            send_element(rand_elem(), rand_elem(), k == len - 1);
        end
    endtask

    task automatic test_reduction_extremes();
        for (int m = vnn_pkg::MODE_L2; m <= vnn_pkg::MODE_DIST; m++) begin
            set_mode(vnn_pkg::t_mode'(m));
            send_element(24'h7F_FFFF, 24'h80_0000, 1'b0);
            send_element(24'h80_0000, 24'h7F_FFFF, 1'b1);
        end
    endtask

    task automatic test_normalize_extremes();
        set_mode(vnn_pkg::MODE_L2N);
        send_element(24'h7F_FFFF, 24'h00_0000, 1'b0);
        send_element(24'h80_0000, 24'hFF_FFFF, 1'b0);
        send_element(24'h00_0001, 24'h00_0000, 1'b1);
        set_mode(vnn_pkg::MODE_L1N);
        send_element(24'h7F_FFFF, 24'h80_0000, 1'b0);
        send_element(24'h80_0000, 24'h00_0000, 1'b0);
        send_element(24'hFF_FFFF, 24'h7F_FFFF, 1'b1);
    endtask

    task automatic test_zero_norm();
        set_mode(vnn_pkg::MODE_L2N);
        send_element(24'h00_0000, 24'h7F_FFFF, 1'b0);
        send_element(24'h00_0000, 24'h80_0000, 1'b1);
        set_mode(vnn_pkg::MODE_L1N);
        send_element(24'h00_0000, 24'hFF_FFFF, 1'b1);
    endtask

    task automatic test_mode_abandon();
        set_mode(vnn_pkg::MODE_L1);
        send_element(24'h40_0000, 24'h00_0000, 1'b0);
        send_element(24'hC0_0000, 24'h00_0000, 1'b0);
        set_mode(vnn_pkg::MODE_MAX);
        send_element(24'h00_0005, 24'h00_0000, 1'b1);
    endtask

    task automatic test_capacity();
        set_mode(vnn_pkg::MODE_L1N);
        idle_on = 1'b0;
        send_vector(vnn_pkg::MAX_LEN + 2);
        wait_quiet();
        idle_on = 1'b1;
    endtask

    task automatic test_backpressure();
        set_mode(vnn_pkg::MODE_L1);
        idle_on  = 1'b0;
        hold_req = 1'b1;
        repeat (12) send_element(rand_elem(), rand_elem(), 1'b1);
        wait_quiet();
        idle_on = 1'b1;
    endtask

    task automatic test_random_vectors();
        int first_item;
        int phase;
        int len;
        first_item = items_sent;
        phase      = 0;
        while (items_sent < first_item + RANDOM_ITEMS) begin
            set_mode(vnn_pkg::t_mode'($urandom_range(7)));
            idle_on = (phase != 1);
            repeat ($urandom_range(1, 4)) begin
                len = ($urandom_range(19) == 0) ? $urandom_range(8, 16)
                                                : $urandom_range(1, 6);
                send_vector(len);
            end
            phase++;
        end
        idle_on = 1'b1;
    endtask

    initial begin
        rst_n         = 1'b0;
        in_if.valid   = 1'b0;
        in_if.elem_a  = '0;
        in_if.elem_b  = '0;
        in_if.is_last = 1'b0;
        cfg_if.valid  = 1'b0;
        cfg_if.data   = vnn_pkg::MODE_L2;
        cur_mode      = vnn_pkg::MODE_L2;
        clear_vector();
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_reduction_extremes();
        test_normalize_extremes();
        test_zero_norm();
        test_mode_abandon();
        test_capacity();
        test_backpressure();
        test_random_vectors();

        wait_quiet();
        if (failures == 0 && queued_values.size() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
